### sv/rti_pkg.sv
// ----------------------------------------------------------------------------
// rti_pkg
// Shared constants for the ray/triangle intersection block: port widths and
// configuration register indexes.
// ----------------------------------------------------------------------------
package rti_pkg;

   localparam int FIELD_WIDTH   = 32;
   localparam int CSR_IDX_WIDTH = 3;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ORIGIN_X = 3'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ORIGIN_Y = 3'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ORIGIN_Z = 3'd2;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIR_X    = 3'd3;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIR_Y    = 3'd4;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_DIR_Z    = 3'd5;

endpackage

### sv/rti_if.sv
// ----------------------------------------------------------------------------
// rti_if
// Valid/ready channels: triangle requests in, hit/distance responses out.
// ----------------------------------------------------------------------------
interface rti_req_if;
   logic valid;
   logic ready;
   logic signed [rti_pkg::FIELD_WIDTH-1:0] a_x, a_y, a_z;
   logic signed [rti_pkg::FIELD_WIDTH-1:0] b_x, b_y, b_z;
   logic signed [rti_pkg::FIELD_WIDTH-1:0] c_x, c_y, c_z;

   modport source (output valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   input ready);
   modport sink   (input valid, a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z,
                   output ready);
endinterface

interface rti_rsp_if;
   logic valid;
   logic ready;
   logic hit;
   logic signed [rti_pkg::FIELD_WIDTH-1:0] distance;

   modport source (output valid, hit, distance, input ready);
   modport sink   (input valid, hit, distance, output ready);
endinterface

### sv/rti_front.sv
// ----------------------------------------------------------------------------
// rti_front
// Edge vectors and the two cross products (pv = dir x p2, qv = tv x p1).
// Three elastic stages: differences, products, subtraction.
// ----------------------------------------------------------------------------
module rti_front #(
   parameter int W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [W-1:0]   org [3],
   input  logic signed [W-1:0]   dir [3],
   input  logic signed [W-1:0]   a [3],
   input  logic signed [W-1:0]   b [3],
   input  logic signed [W-1:0]   c [3],
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [W:0]     p1_o [3],
   output logic signed [W:0]     p2_o [3],
   output logic signed [W:0]     tv_o [3],
   output logic signed [W:0]     dr_o [3],
   output logic signed [2*W+2:0] pv_o [3],
   output logic signed [2*W+2:0] qv_o [3]
);
   localparam int D = W + 1;
   localparam int M = 2 * D;
   localparam int C = 2 * D + 1;
   localparam int S = 3;

   logic [S-1:0] v_ff;
   logic [S:0]   en;

   logic signed [D-1:0] p1_in [3], p2_in [3], tv_in [3], dr_in [3];
   logic signed [D-1:0] p1_ff [2][3], p2_ff [2][3], tv_ff [2][3], dr_ff [2][3];
   logic signed [M-1:0] m_in [12], m_ff [12];
   logic signed [C-1:0] pv_ff [3], qv_ff [3];

   always_comb begin
      en[S] = out_ready;
      for (int k = S - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[S-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < S; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p1_in[i] = {b[i][W-1], b[i]} - {a[i][W-1], a[i]};
         p2_in[i] = {c[i][W-1], c[i]} - {a[i][W-1], a[i]};
         tv_in[i] = {org[i][W-1], org[i]} - {a[i][W-1], a[i]};
         dr_in[i] = {dir[i][W-1], dir[i]};
      end
      // pv = dr x p2
      m_in[0]  = dr_ff[0][1] * p2_ff[0][2];
      m_in[1]  = dr_ff[0][2] * p2_ff[0][1];
      m_in[2]  = dr_ff[0][2] * p2_ff[0][0];
      m_in[3]  = dr_ff[0][0] * p2_ff[0][2];
      m_in[4]  = dr_ff[0][0] * p2_ff[0][1];
      m_in[5]  = dr_ff[0][1] * p2_ff[0][0];
      // qv = tv x p1
      m_in[6]  = tv_ff[0][1] * p1_ff[0][2];
      m_in[7]  = tv_ff[0][2] * p1_ff[0][1];
      m_in[8]  = tv_ff[0][2] * p1_ff[0][0];
      m_in[9]  = tv_ff[0][0] * p1_ff[0][2];
      m_in[10] = tv_ff[0][0] * p1_ff[0][1];
      m_in[11] = tv_ff[0][1] * p1_ff[0][0];
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         p1_ff[0] <= p1_in;
         p2_ff[0] <= p2_in;
         tv_ff[0] <= tv_in;
         dr_ff[0] <= dr_in;
      end
      if (en[1]) begin
         p1_ff[1] <= p1_ff[0];
         p2_ff[1] <= p2_ff[0];
         tv_ff[1] <= tv_ff[0];
         dr_ff[1] <= dr_ff[0];
         m_ff     <= m_in;
      end
      if (en[2]) begin
         for (int i = 0; i < 3; i++) begin
            pv_ff[i] <= C'(m_ff[2*i]) - C'(m_ff[2*i+1]);
            qv_ff[i] <= C'(m_ff[6+2*i]) - C'(m_ff[6+2*i+1]);
         end
         p1_o <= p1_ff[1];
         p2_o <= p2_ff[1];
         tv_o <= tv_ff[1];
         dr_o <= dr_ff[1];
      end
   end

   assign pv_o = pv_ff;
   assign qv_o = qv_ff;

endmodule

### sv/rti_dot.sv
// ----------------------------------------------------------------------------
// rti_dot
// The four dot products det, un, vn, tn. Each wide product is split into two
// partial products, recombined, then summed: three elastic stages.
// ----------------------------------------------------------------------------
module rti_dot #(
   parameter int W = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [W:0]     p1 [3],
   input  logic signed [W:0]     p2 [3],
   input  logic signed [W:0]     tv [3],
   input  logic signed [W:0]     dr [3],
   input  logic signed [2*W+2:0] pv [3],
   input  logic signed [2*W+2:0] qv [3],
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic signed [3*W+5:0] sum_o [4]
);
   localparam int D = W + 1;
   localparam int C = 2 * D + 1;
   localparam int L = D + 1;
   localparam int P = 3 * D + 3;
   localparam int S = 3;

   logic [S-1:0] v_ff;
   logic [S:0]   en;

   logic signed [D-1:0]   x_sel [12];
   logic signed [C-1:0]   y_sel [12];
   logic signed [D+L:0]   lo_ff [12];
   logic signed [2*D-1:0] hi_ff [12];
   logic signed [P-1:0]   prod_ff [12];
   logic signed [P-1:0]   sum_ff [4];

   always_comb begin
      en[S] = out_ready;
      for (int k = S - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[S-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < S; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // group 0: det = p1.pv, 1: un = tv.pv, 2: vn = dr.qv, 3: tn = p2.qv
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         x_sel[i]   = p1[i];  y_sel[i]   = pv[i];
         x_sel[3+i] = tv[i];  y_sel[3+i] = pv[i];
         x_sel[6+i] = dr[i];  y_sel[6+i] = qv[i];
         x_sel[9+i] = p2[i];  y_sel[9+i] = qv[i];
      end
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         for (int j = 0; j < 12; j++) begin
            lo_ff[j] <= x_sel[j] * $signed({1'b0, y_sel[j][L-1:0]});
            hi_ff[j] <= x_sel[j] * $signed(y_sel[j][C-1:L]);
         end
      end
      if (en[1]) begin
         for (int j = 0; j < 12; j++) begin
            prod_ff[j] <= (P'(hi_ff[j]) <<< L) + P'(lo_ff[j]);
         end
      end
      if (en[2]) begin
         for (int g = 0; g < 4; g++) begin
            sum_ff[g] <= prod_ff[3*g] + prod_ff[3*g+1] + prod_ff[3*g+2];
         end
      end
   end

   assign sum_o = sum_ff;

endmodule

### sv/rti_test.sv
// ----------------------------------------------------------------------------
// rti_test
// Sign normalization, the u/v bound tests and the quotient overflow check.
// Three elastic stages.
// ----------------------------------------------------------------------------
module rti_test #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  logic signed [3*W+5:0] sum_i [4],
   output logic                  out_valid,
   input  logic                  out_ready,
   output logic                  hit_o,
   output logic                  neg_o,
   output logic                  ovf_o,
   output logic [3*W+5+F:0]      num_o,
   output logic [3*W+5:0]        det_o
);
   localparam int P = 3 * W + 6;
   localparam int N = P + F;
   localparam int S = 3;

   logic [S-1:0] v_ff;
   logic [S:0]   en;

   logic signed [P-1:0] det_ff, un_ff, vn_ff, tn_ff;
   logic                nz_ff;
   logic signed [P+1:0] du_full, duv_full;
   logic                ok_in, ok_ff, hit_ff;
   logic [P-1:0]        tmag_in, tmag_ff, det1_ff, det2_ff;
   logic                neg_ff, neg2_ff, ovf_ff;
   logic [N-1:0]        num_in, num_ff;

   always_comb begin
      en[S] = out_ready;
      for (int k = S - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[S-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < S; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   always_comb begin
      du_full  = (P+2)'(det_ff) - (P+2)'(un_ff);
      duv_full = (P+2)'(det_ff) - (P+2)'(un_ff) - (P+2)'(vn_ff);
      ok_in    = nz_ff && !un_ff[P-1] && !du_full[P+1] && !vn_ff[P-1]
                 && !duv_full[P+1];
      tmag_in  = tn_ff[P-1] ? P'(-tn_ff) : P'(tn_ff);
      num_in   = N'(tmag_ff) << F;
   end

   always_ff @(posedge clock) begin
      if (en[0]) begin
         nz_ff <= (sum_i[0] != '0);
         if (sum_i[0][P-1]) begin
            det_ff <= -sum_i[0];
            un_ff  <= -sum_i[1];
            vn_ff  <= -sum_i[2];
            tn_ff  <= -sum_i[3];
         end else begin
            det_ff <= sum_i[0];
            un_ff  <= sum_i[1];
            vn_ff  <= sum_i[2];
            tn_ff  <= sum_i[3];
         end
      end
      if (en[1]) begin
         ok_ff   <= ok_in;
         tmag_ff <= tmag_in;
         neg_ff  <= tn_ff[P-1];
         det1_ff <= P'(det_ff);
      end
      if (en[2]) begin
         hit_ff  <= ok_ff;
         neg2_ff <= neg_ff;
         num_ff  <= num_in;
         det2_ff <= det1_ff;
         // quotient of at least 2^W saturates in any case
         ovf_ff  <= (N + W)'(num_in) >= ((N + W)'(det1_ff) << W);
      end
   end

   assign hit_o = hit_ff;
   assign neg_o = neg2_ff;
   assign ovf_o = ovf_ff;
   assign num_o = num_ff;
   assign det_o = det2_ff;

endmodule

### sv/rti_div.sv
// ----------------------------------------------------------------------------
// rti_div
// Restoring divider, one quotient bit per stage (W stages), then a stage
// for sign and saturation.
// ----------------------------------------------------------------------------
module rti_div #(
   parameter int W = 32,
   parameter int F = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic                hit_i,
   input  logic                neg_i,
   input  logic                ovf_i,
   input  logic [3*W+5+F:0]    num_i,
   input  logic [3*W+5:0]      det_i,
   output logic                out_valid,
   input  logic                out_ready,
   output logic                hit_o,
   output logic signed [W-1:0] dist_o
);
   localparam int P = 3 * W + 6;
   localparam int N = P + F;
   localparam int S = W + 1;

   logic [S-1:0] v_ff;
   logic [S:0]   en;

   logic [P-1:0] rem_ff [W], rem_src [W], rem_in [W];
   logic [W-1:0] q_ff [W], q_src [W], q_in [W];
   logic [W-1:0] lo_ff [W], lo_src [W];
   logic [P-1:0] det_ff [W], det_src [W];
   logic         hit_ff [W], hit_src [W];
   logic         neg_ff [W], neg_src [W];
   logic         ovf_ff [W], ovf_src [W];
   logic [N-1:0] nsh;
   logic [P:0]   trial [W];
   logic [P:0]   diff [W];

   logic                hit_out_ff;
   logic signed [W-1:0] dist_in, dist_ff;
   logic [W-1:0]        qf;
   logic                sat;

   always_comb begin
      en[S] = out_ready;
      for (int k = S - 1; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign in_ready  = en[0];
   assign out_valid = v_ff[S-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) begin
            v_ff[0] <= in_valid;
         end
         for (int k = 1; k < S; k++) begin
            if (en[k]) begin
               v_ff[k] <= v_ff[k-1];
            end
         end
      end
   end

   // stage k produces quotient bit W-1-k
   always_comb begin
      nsh        = num_i >> W;
      rem_src[0] = nsh[P-1:0];
      q_src[0]   = '0;
      lo_src[0]  = num_i[W-1:0];
      det_src[0] = det_i;
      hit_src[0] = hit_i;
      neg_src[0] = neg_i;
      ovf_src[0] = ovf_i;
      for (int k = 1; k < W; k++) begin
         rem_src[k] = rem_ff[k-1];
         q_src[k]   = q_ff[k-1];
         lo_src[k]  = lo_ff[k-1];
         det_src[k] = det_ff[k-1];
         hit_src[k] = hit_ff[k-1];
         neg_src[k] = neg_ff[k-1];
         ovf_src[k] = ovf_ff[k-1];
      end
      for (int k = 0; k < W; k++) begin
         trial[k] = {rem_src[k], lo_src[k][W-1-k]};
         diff[k]  = trial[k] - {1'b0, det_src[k]};
         if (!diff[k][P]) begin
            rem_in[k] = diff[k][P-1:0];
            q_in[k]   = {q_src[k][W-2:0], 1'b1};
         end else begin
            rem_in[k] = trial[k][P-1:0];
            q_in[k]   = {q_src[k][W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < W; k++) begin
         if (en[k]) begin
            rem_ff[k] <= rem_in[k];
            q_ff[k]   <= q_in[k];
            lo_ff[k]  <= lo_src[k];
            det_ff[k] <= det_src[k];
            hit_ff[k] <= hit_src[k];
            neg_ff[k] <= neg_src[k];
            ovf_ff[k] <= ovf_src[k];
         end
      end
   end

   always_comb begin
      qf = q_ff[W-1];
      if (neg_ff[W-1]) begin
         sat     = ovf_ff[W-1] || (qf[W-1] && (qf[W-2:0] != '0));
         dist_in = sat ? $signed({1'b1, {(W-1){1'b0}}}) : $signed(-qf);
      end else begin
         sat     = ovf_ff[W-1] || qf[W-1];
         dist_in = sat ? $signed({1'b0, {(W-1){1'b1}}}) : $signed(qf);
      end
      if (!hit_ff[W-1]) begin
         dist_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en[W]) begin
         hit_out_ff <= hit_ff[W-1];
         dist_ff    <= dist_in;
      end
   end

   assign hit_o  = hit_out_ff;
   assign dist_o = dist_ff;

endmodule

### sv/ray_triangle_intersect.sv
// ----------------------------------------------------------------------------
// ray_triangle_intersect
// Moller-Trumbore ray/triangle test in exact fixed point, fully pipelined.
// ----------------------------------------------------------------------------
// One triangle per beat, one hit/distance beat per triangle, in order. The
// ray (origin, direction) sits in six CSRs; write them only while the
// pipeline is empty. Throughput is one triangle per cycle while rsp_ch
// accepts; the stages are 3 front, 3 dot product, 3 test, COORD_WIDTH
// divider stages of one quotient bit each, 1 saturation. Every stage is an
// elastic register with its own valid bit, so a stalled response only holds
// the stages behind it and bubbles collapse. All arithmetic is exact: det,
// u and v numerators and the t numerator are kept at full width; the u/v
// bounds are compared against det, and only t is divided (truncated toward
// zero, saturated to COORD_WIDTH bits, sign-extended onto distance).
// A zero det is a miss; a miss reports distance 0.
// ----------------------------------------------------------------------------
module ray_triangle_intersect #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS   = 16
) (
   input  logic                                 clock,
   input  logic                                 reset,
   rti_req_if.sink                              req_ch,
   rti_rsp_if.source                            rsp_ch,
   input  logic                                 csr_wr_en,
   input  logic [rti_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [rti_pkg::FIELD_WIDTH-1:0]      csr_wdata
);
   localparam int W = COORD_WIDTH;
   localparam int F = FRAC_BITS;
   localparam int P = 3 * W + 6;

   // ray registers
   logic [rti_pkg::FIELD_WIDTH-1:0] org_ff [3];
   logic [rti_pkg::FIELD_WIDTH-1:0] dir_ff [3];

   always_ff @(posedge clock) begin
      if (reset) begin
         org_ff <= '{default: '0};
         dir_ff <= '{default: '0};
      end else if (csr_wr_en) begin
         case (csr_index)
            rti_pkg::CSR_ORIGIN_X: org_ff[0] <= csr_wdata;
            rti_pkg::CSR_ORIGIN_Y: org_ff[1] <= csr_wdata;
            rti_pkg::CSR_ORIGIN_Z: org_ff[2] <= csr_wdata;
            rti_pkg::CSR_DIR_X:    dir_ff[0] <= csr_wdata;
            rti_pkg::CSR_DIR_Y:    dir_ff[1] <= csr_wdata;
            rti_pkg::CSR_DIR_Z:    dir_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // only the low COORD_WIDTH bits of every coordinate take part
   logic signed [W-1:0] org_w [3], dir_w [3], a_w [3], b_w [3], c_w [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         org_w[i] = org_ff[i][W-1:0];
         dir_w[i] = dir_ff[i][W-1:0];
      end
      a_w[0] = req_ch.a_x[W-1:0];
      a_w[1] = req_ch.a_y[W-1:0];
      a_w[2] = req_ch.a_z[W-1:0];
      b_w[0] = req_ch.b_x[W-1:0];
      b_w[1] = req_ch.b_y[W-1:0];
      b_w[2] = req_ch.b_z[W-1:0];
      c_w[0] = req_ch.c_x[W-1:0];
      c_w[1] = req_ch.c_y[W-1:0];
      c_w[2] = req_ch.c_z[W-1:0];
   end

   // front: edges and cross products
   logic                  fr_valid, fr_ready;
   logic signed [W:0]     p1 [3], p2 [3], tv [3], dr [3];
   logic signed [2*W+2:0] pv [3], qv [3];

   rti_front #(.W(W)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_ch.valid),
      .in_ready  (req_ch.ready),
      .org       (org_w),
      .dir       (dir_w),
      .a         (a_w),
      .b         (b_w),
      .c         (c_w),
      .out_valid (fr_valid),
      .out_ready (fr_ready),
      .p1_o      (p1),
      .p2_o      (p2),
      .tv_o      (tv),
      .dr_o      (dr),
      .pv_o      (pv),
      .qv_o      (qv)
   );

   // dot products: det, un, vn, tn
   logic                dt_valid, dt_ready;
   logic signed [P-1:0] sums [4];

   rti_dot #(.W(W)) u_dot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (fr_valid),
      .in_ready  (fr_ready),
      .p1        (p1),
      .p2        (p2),
      .tv        (tv),
      .dr        (dr),
      .pv        (pv),
      .qv        (qv),
      .out_valid (dt_valid),
      .out_ready (dt_ready),
      .sum_o     (sums)
   );

   // bound tests and overflow check
   logic           ts_valid, ts_ready, ts_hit, ts_neg, ts_ovf;
   logic [P+F-1:0] ts_num;
   logic [P-1:0]   ts_det;

   rti_test #(.W(W), .F(F)) u_test (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dt_valid),
      .in_ready  (dt_ready),
      .sum_i     (sums),
      .out_valid (ts_valid),
      .out_ready (ts_ready),
      .hit_o     (ts_hit),
      .neg_o     (ts_neg),
      .ovf_o     (ts_ovf),
      .num_o     (ts_num),
      .det_o     (ts_det)
   );

   // t = tn * 2^F / det
   logic signed [W-1:0] t_dist;

   rti_div #(.W(W), .F(F)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ts_valid),
      .in_ready  (ts_ready),
      .hit_i     (ts_hit),
      .neg_i     (ts_neg),
      .ovf_i     (ts_ovf),
      .num_i     (ts_num),
      .det_i     (ts_det),
      .out_valid (rsp_ch.valid),
      .out_ready (rsp_ch.ready),
      .hit_o     (rsp_ch.hit),
      .dist_o    (t_dist)
   );

   assign rsp_ch.distance = rti_pkg::FIELD_WIDTH'(t_dist);

endmodule
